/* rtl/core/pdsp_pkg.sv */
// Shared types, constants and field helpers for the point projection depth splat core.
package pdsp_pkg;

    localparam int AW       = 12;            // depth store address bits
    localparam int DEPTH    = 4096;          // depth store entries
    localparam int QB       = 12;            // quotient bits kept by the divider
    localparam int NW       = 64;            // divider datapath width
    localparam int PW       = 50;            // width of the transform and intrinsic sums
    localparam logic [31:0] EMPTY_MARK = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_ROT_X  = 3'd0,
        REG_ROT_Y  = 3'd1,
        REG_ROT_Z  = 3'd2,
        REG_INTR_A = 3'd3,
        REG_INTR_B = 3'd4,
        REG_INTR_C = 3'd5
    } t_reg_idx;

    // Control that rides along with a beat up to the divider.
    typedef struct packed {
        logic          v;
        logic          cmd;
        logic [AW-1:0] idx;
    } t_tag;

    // Control that rides alongside the divider lanes.
    typedef struct packed {
        logic               v;
        logic               cmd;
        logic [AW-1:0]      idx;
        logic signed [31:0] cz;
        logic               neg0;
        logic               neg1;
        logic               zero;
    } t_side;

    // Signed 16-bit coefficient k of a packed register.
    function automatic logic signed [15:0] fld(input logic [63:0] r, input logic [1:0] k);
        return $signed(r[16*k +: 16]);
    endfunction

endpackage

/* rtl/core/pdsp_div.sv */
// Pipelined restoring divider: one quotient bit per stage, with an overflow flag.
module pdsp_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [pdsp_pkg::NW-1:0]   i_num,
    input  logic [pdsp_pkg::NW-1:0]   i_den,
    output logic [pdsp_pkg::QB-1:0]   o_quo,
    output logic                      o_ovf
);
    localparam int QB = pdsp_pkg::QB;
    localparam int NW = pdsp_pkg::NW;

    logic [NW-1:0] r_rem [0:QB-1];
    logic [NW-1:0] r_den [0:QB-1];
    logic [QB-1:0] r_quo [0:QB];
    logic          r_ovf [0:QB];

    // quotient would not fit in QB bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= (i_num >= (i_den << QB));
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        localparam int B = QB - k;
        logic [NW-1:0] dsh;
        logic          ge;
        assign dsh = r_den[k-1] << B;
        assign ge  = (r_rem[k-1] >= dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= ge ? (r_quo[k-1] | (QB'(1) << B)) : r_quo[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < QB) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? (r_rem[k-1] - dsh) : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_quo = r_quo[QB];
    assign o_ovf = r_ovf[QB];

endmodule

/* rtl/core/point_projection_depth_splat_core.sv */
// Top level: rigid transform, intrinsics, divide, and depth map store.
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_ready | i_command i_world_x/y/z i_read_index
//  out     | output    | o_out_valid/i_out_ready | o_hit o_pixel_row/col o_depth_value o_is_empty
//  cfg     | input     | psel penable pwrite pready | paddr pwdata prdata
//
// One beat per cycle enters while o_in_ready is high; a result passes five multiply/sum stages,
// 13 divider stages, a range check stage and the depth store access.
// After reset the 4096 depth store entries are swept to the empty marker; o_in_ready
// stays low during the sweep. The store is one single-port memory: each beat makes one
// read or one write in its last stage, so beats see each other in order.
// A stalled output freezes the whole pipeline.
module point_projection_depth_splat_core #(
    parameter int IMG_WIDTH  = 64,
    parameter int IMG_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic signed [31:0] i_world_x,
    input  logic signed [31:0] i_world_y,
    input  logic signed [31:0] i_world_z,
    input  logic [11:0]        i_read_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit,
    output logic [5:0]         o_pixel_row,
    output logic [5:0]         o_pixel_col,
    output logic signed [31:0] o_depth_value,
    output logic               o_is_empty,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    localparam int AW = pdsp_pkg::AW;
    localparam int PW = pdsp_pkg::PW;
    localparam int NW = pdsp_pkg::NW;
    localparam int QB = pdsp_pkg::QB;
    localparam int LW = 2 * QB + 1;

    // ---------------- configuration ----------------
    logic [63:0] r_rot  [3];
    logic [47:0] r_intr [3];
    logic        cfg_wr;
    pdsp_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = pdsp_pkg::t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]  <= 64'd16384;
            r_rot[1]  <= 64'd1073741824;
            r_rot[2]  <= 64'd70368744177664;
            r_intr[0] <= 48'd16;
            r_intr[1] <= 48'd1048576;
            r_intr[2] <= 48'd68719476736;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                pdsp_pkg::REG_ROT_X:  r_rot[0]  <= pwdata;
                pdsp_pkg::REG_ROT_Y:  r_rot[1]  <= pwdata;
                pdsp_pkg::REG_ROT_Z:  r_rot[2]  <= pwdata;
                pdsp_pkg::REG_INTR_A: r_intr[0] <= pwdata[47:0];
                pdsp_pkg::REG_INTR_B: r_intr[1] <= pwdata[47:0];
                pdsp_pkg::REG_INTR_C: r_intr[2] <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            pdsp_pkg::REG_ROT_X:  prdata = r_rot[0];
            pdsp_pkg::REG_ROT_Y:  prdata = r_rot[1];
            pdsp_pkg::REG_ROT_Z:  prdata = r_rot[2];
            pdsp_pkg::REG_INTR_A: prdata = {16'd0, r_intr[0]};
            pdsp_pkg::REG_INTR_B: prdata = {16'd0, r_intr[1]};
            pdsp_pkg::REG_INTR_C: prdata = {16'd0, r_intr[2]};
            default:              prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic r_clr_busy;
    logic [AW-1:0] r_clr_cnt;
    logic r_o_valid;
    logic en;
    logic acc;

    assign en         = !r_o_valid || i_out_ready;
    assign o_in_ready = en && !r_clr_busy;
    assign acc        = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == AW'(pdsp_pkg::DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    function automatic logic signed [31:0] to_q16(input logic signed [PW-1:0] s,
                                                  input logic zsat);
        logic [PW-1:0]        mag;
        logic [PW-1:0]        q;
        logic signed [PW-1:0] r;
        logic signed [PW-1:0] lo;
        logic signed [PW-1:0] hi;
        mag = s[PW-1] ? PW'(-s) : PW'(s);
        q   = (mag + PW'(8192)) >> 14;
        r   = s[PW-1] ? -$signed(q) : $signed(q);
        lo  = zsat ? PW'(-64'sd2147483647) : PW'(-64'sd2147483648);
        hi  = PW'(64'sd2147483647);
        if (r < lo) begin
            r = lo;
        end else if (r > hi) begin
            r = hi;
        end
        return r[31:0];
    endfunction

    // ---------------- transform and intrinsics ----------------
    logic signed [31:0] w_in [3];
    assign w_in[0] = i_world_x;
    assign w_in[1] = i_world_y;
    assign w_in[2] = i_world_z;

    pdsp_pkg::t_tag r1_tag, r2_tag, r3_tag, r4_tag, r5_tag;
    logic signed [47:0] r1_prod [3][3];
    logic signed [15:0] r1_t    [3];
    logic signed [PW-1:0] r2_sum [3];
    logic signed [31:0] r3_c [3];
    logic signed [47:0] r4_kp [3][3];
    logic signed [31:0] r4_cz;
    logic signed [PW-1:0] r5_p [3];
    logic signed [31:0] r5_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
            r4_tag <= '0;
            r5_tag <= '0;
        end else if (en) begin
            r1_tag <= '{v: acc, cmd: i_command, idx: i_read_index};
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
            r4_tag <= r3_tag;
            r5_tag <= r4_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r1_prod[i][j] <= pdsp_pkg::fld(r_rot[i], 2'(j)) * w_in[j];
                    r4_kp[i][j]   <= pdsp_pkg::fld({16'd0, r_intr[i]}, 2'(j)) * r3_c[j];
                end
                r1_t[i]   <= pdsp_pkg::fld(r_rot[i], 2'd3);
                r2_sum[i] <= PW'(r1_prod[i][0]) + PW'(r1_prod[i][1]) + PW'(r1_prod[i][2])
                           + (PW'(r1_t[i]) <<< 22);
                r3_c[i]   <= to_q16(r2_sum[i], (i == 2));
                r5_p[i]   <= PW'(r4_kp[i][0]) + PW'(r4_kp[i][1]) + PW'(r4_kp[i][2]);
            end
            r4_cz <= r3_c[2];
            r5_cz <= r4_cz;
        end
    end

    // ---------------- divider ----------------
    logic [PW-1:0] an0, an1, ad;
    logic [NW-1:0] num0, num1, den;
    logic [QB-1:0] q0, q1;
    logic          ovf0, ovf1;

    assign an0  = r5_p[0][PW-1] ? PW'(-r5_p[0]) : PW'(r5_p[0]);
    assign an1  = r5_p[1][PW-1] ? PW'(-r5_p[1]) : PW'(r5_p[1]);
    assign ad   = r5_p[2][PW-1] ? PW'(-r5_p[2]) : PW'(r5_p[2]);
    assign num0 = NW'({an0, 1'b0}) + NW'(ad);
    assign num1 = NW'({an1, 1'b0}) + NW'(ad);
    assign den  = NW'({ad, 1'b0});

    pdsp_div u_div_row (
        .i_clk (i_clk), .i_en (en), .i_num (num0), .i_den (den), .o_quo (q0), .o_ovf (ovf0)
    );
    pdsp_div u_div_col (
        .i_clk (i_clk), .i_en (en), .i_num (num1), .i_den (den), .o_quo (q1), .o_ovf (ovf1)
    );

    pdsp_pkg::t_side r_sb [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_sb[k] <= '0;
            end
        end else if (en) begin
            r_sb[0] <= '{v: r5_tag.v, cmd: r5_tag.cmd, idx: r5_tag.idx, cz: r5_cz,
                         neg0: r5_p[0][PW-1] ^ r5_p[2][PW-1],
                         neg1: r5_p[1][PW-1] ^ r5_p[2][PW-1],
                         zero: (r5_p[2] == '0)};
            for (int k = 1; k <= QB; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // ---------------- range check ----------------
    pdsp_pkg::t_side sb;
    logic          row_ok, col_ok, idx_ok, n_hit;
    logic [LW-1:0] n_lin;

    assign sb     = r_sb[QB];
    // a negative quotient counts only when it rounds to zero
    assign row_ok = !ovf0 && (!sb.neg0 || q0 == '0)
                    && ({1'b0, q0} < (QB+1)'(IMG_HEIGHT));
    assign col_ok = !ovf1 && (!sb.neg1 || q1 == '0)
                    && ({1'b0, q1} < (QB+1)'(IMG_WIDTH));
    assign n_lin  = LW'(q0) * LW'(IMG_WIDTH) + LW'(q1);
    assign idx_ok = n_lin < LW'(pdsp_pkg::DEPTH);
    assign n_hit  = !sb.cmd && !sb.zero && row_ok && col_ok && idx_ok;

    logic               r_m_v, r_m_cmd, r_m_hit;
    logic [AW-1:0]      r_m_addr;
    logic [5:0]         r_m_row, r_m_col;
    logic signed [31:0] r_m_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= sb.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_cmd  <= sb.cmd;
            r_m_hit  <= n_hit;
            r_m_addr <= sb.cmd ? sb.idx : n_lin[AW-1:0];
            r_m_row  <= n_hit ? q0[5:0] : 6'd0;
            r_m_col  <= n_hit ? q1[5:0] : 6'd0;
            r_m_cz   <= sb.cz;
        end
    end

    // ---------------- depth store ----------------
    logic [31:0] mem [pdsp_pkg::DEPTH];
    logic [31:0] r_q;
    logic        mem_wr;

    assign mem_wr = en && r_m_v && r_m_hit;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_cnt] <= pdsp_pkg::EMPTY_MARK;
        end else if (mem_wr) begin
            mem[r_m_addr] <= r_m_cz;
        end
        if (en && r_m_v && r_m_cmd) begin
            r_q <= mem[r_m_addr];
        end
    end

    // ---------------- output register ----------------
    logic               r_o_hit, r_o_cmd;
    logic [5:0]         r_o_row, r_o_col;
    logic signed [31:0] r_o_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_hit <= r_m_hit;
            r_o_cmd <= r_m_cmd;
            r_o_row <= r_m_row;
            r_o_col <= r_m_col;
            r_o_cz  <= r_m_cz;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_hit         = r_o_hit;
    assign o_pixel_row   = r_o_row;
    assign o_pixel_col   = r_o_col;
    assign o_depth_value = r_o_cmd ? $signed(r_q) : r_o_cz;
    assign o_is_empty    = r_o_cmd && (r_q == pdsp_pkg::EMPTY_MARK);

    // ---------------- assertions ----------------
    a_clr_empty_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_m_v && !r_o_valid)
        else $error("beat in pipeline during store sweep");

    a_no_wr_in_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !mem_wr)
        else $error("splat write during store sweep");

    a_hit_not_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> !o_is_empty && o_depth_value != $signed(pdsp_pkg::EMPTY_MARK))
        else $error("hit result carries the empty marker");

endmodule

/* tb/pdsp_checker.sv */
// Checker for the projection core: watches all three channels, predicts results and compares them.
module pdsp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_command,
    input  logic signed [31:0] i_world_x,
    input  logic signed [31:0] i_world_y,
    input  logic signed [31:0] i_world_z,
    input  logic [11:0]        i_read_index,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_hit,
    input  logic [5:0]         i_pixel_row,
    input  logic [5:0]         i_pixel_col,
    input  logic signed [31:0] i_depth_value,
    input  logic               i_is_empty,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [5:0]         i_paddr,
    input  logic [63:0]        i_pwdata,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMG_W = 64;
    localparam int IMG_H = 64;

    typedef struct packed {
        logic        hit;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] depth;
        logic        empty;
    } t_pix_res;

    logic [63:0] regs [6];
    logic [31:0] depth_map [pdsp_pkg::DEPTH];
    t_pix_res    pixel_q [$];

    function automatic longint coef(input logic [63:0] r, input int k);
        logic signed [15:0] f;
        f = r[16*k +: 16];
        return longint'(f);
    endfunction

    function automatic longint round_q16(input longint v, input longint lo);
        longint m;
        longint q;
        m = (v < 0) ? -v : v;
        q = (m + 64'sd8192) >>> 14;
        if (v < 0) q = -q;
        if (q < lo) q = lo;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        return q;
    endfunction

    function automatic longint cam_coord(input logic [63:0] r, input longint w0,
                                         input longint w1, input longint w2,
                                         input longint lo);
        longint s;
        s = coef(r, 0) * w0 + coef(r, 1) * w1 + coef(r, 2) * w2 + coef(r, 3) * (64'sd1 << 22);
        return round_q16(s, lo);
    endfunction

    // round num/den half away from zero; in range only when inside [0, lim)
    function automatic bit div_round(input longint num, input longint den, input int lim,
                                     output int q);
        logic [63:0] an;
        logic [63:0] ad;
        logic [63:0] qq;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        qq = (2 * an + ad) / (2 * ad);
        q = 0;
        if (((num < 0) != (den < 0)) && qq != 0) return 0;
        if (qq >= lim) return 0;
        q = int'(qq);
        return 1;
    endfunction

    function automatic t_pix_res project_point(input logic cmd, input logic [31:0] wx,
                                               input logic [31:0] wy, input logic [31:0] wz,
                                               input logic [11:0] ridx);
        t_pix_res res;
        longint c0, c1, c2, p0, p1, p2;
        int row, col;
        res = '0;
        if (cmd) begin
            res.depth = depth_map[ridx];
            res.empty = (res.depth == pdsp_pkg::EMPTY_MARK);
            return res;
        end
        c0 = cam_coord(regs[pdsp_pkg::REG_ROT_X], $signed(wx), $signed(wy), $signed(wz),
                       -64'sd2147483648);
        c1 = cam_coord(regs[pdsp_pkg::REG_ROT_Y], $signed(wx), $signed(wy), $signed(wz),
                       -64'sd2147483648);
        c2 = cam_coord(regs[pdsp_pkg::REG_ROT_Z], $signed(wx), $signed(wy), $signed(wz),
                       -64'sd2147483647);
        res.depth = c2[31:0];
        p0 = coef(regs[pdsp_pkg::REG_INTR_A], 0) * c0 + coef(regs[pdsp_pkg::REG_INTR_A], 1) * c1
           + coef(regs[pdsp_pkg::REG_INTR_A], 2) * c2;
        p1 = coef(regs[pdsp_pkg::REG_INTR_B], 0) * c0 + coef(regs[pdsp_pkg::REG_INTR_B], 1) * c1
           + coef(regs[pdsp_pkg::REG_INTR_B], 2) * c2;
        p2 = coef(regs[pdsp_pkg::REG_INTR_C], 0) * c0 + coef(regs[pdsp_pkg::REG_INTR_C], 1) * c1
           + coef(regs[pdsp_pkg::REG_INTR_C], 2) * c2;
        if (p2 == 0) return res;
        if (!div_round(p0, p2, IMG_H, row)) return res;
        if (!div_round(p1, p2, IMG_W, col)) return res;
        if (row * IMG_W + col >= pdsp_pkg::DEPTH) return res;
        depth_map[row * IMG_W + col] = c2[31:0];
        res.hit = 1'b1;
        res.row = row[5:0];
        res.col = col[5:0];
        return res;
    endfunction

    assign o_pending = pixel_q.size();

    always @(posedge i_clk) begin
        t_pix_res want;
        t_pix_res got;
        if (!i_rst_n) begin
            regs[pdsp_pkg::REG_ROT_X]  <= 64'd16384;
            regs[pdsp_pkg::REG_ROT_Y]  <= 64'd1073741824;
            regs[pdsp_pkg::REG_ROT_Z]  <= 64'd70368744177664;
            regs[pdsp_pkg::REG_INTR_A] <= 64'd16;
            regs[pdsp_pkg::REG_INTR_B] <= 64'd1048576;
            regs[pdsp_pkg::REG_INTR_C] <= 64'd68719476736;
            for (int i = 0; i < pdsp_pkg::DEPTH; i++) depth_map[i] = pdsp_pkg::EMPTY_MARK;
            pixel_q.delete();
            o_errors <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_paddr[5:3] <= pdsp_pkg::REG_INTR_C) begin
                if (i_paddr[5:3] >= pdsp_pkg::REG_INTR_A)
                    regs[i_paddr[5:3]] <= {16'd0, i_pwdata[47:0]};
                else
                    regs[i_paddr[5:3]] <= i_pwdata;
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_hit, i_pixel_row, i_pixel_col, i_depth_value, i_is_empty};
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected result beat, actual %h", $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pixel_q.pop_front();
                    if (want !== got) begin
                        $display("%0t: mismatch expected hit=%b row=%0d col=%0d depth=%h empty=%b",
                                 $realtime, want.hit, want.row, want.col, want.depth, want.empty);
                        $display("%0t:          actual   hit=%b row=%0d col=%0d depth=%h empty=%b",
                                 $realtime, got.hit, got.row, got.col, got.depth, got.empty);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pixel_q = {pixel_q, project_point(i_command, i_world_x, i_world_y, i_world_z,
                                                  i_read_index)};
        end
    end
endmodule

/* tb/tb.sv */
// Testbench top: drives points, reads and register writes into the projection core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM   = 1600;
    localparam int  STALL_MAX  = 20000;
    localparam int  DRAIN_WAIT = 40;
    localparam logic CMD_SPLAT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_command = 1'b0;
    logic signed [31:0] i_world_x = '0;
    logic signed [31:0] i_world_y = '0;
    logic signed [31:0] i_world_z = '0;
    logic [11:0]        i_read_index = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_hit;
    logic [5:0]         o_pixel_row;
    logic [5:0]         o_pixel_col;
    logic signed [31:0] o_depth_value;
    logic               o_is_empty;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [5:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    int                 errors;
    int                 pending;
    int                 send_idle_pct = 26;
    int                 recv_idle_pct = 66;
    bit                 recv_hold = 1'b0;
    int                 quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    point_projection_depth_splat_core dut (.*);

    pdsp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_command(i_command), .i_world_x(i_world_x), .i_world_y(i_world_y),
        .i_world_z(i_world_z), .i_read_index(i_read_index), .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .i_hit(o_hit), .i_pixel_row(o_pixel_row),
        .i_pixel_col(o_pixel_col), .i_depth_value(o_depth_value), .i_is_empty(o_is_empty),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    // receiver: random backpressure unless a long hold is in progress
    always @(negedge i_clk) begin
        if (recv_hold) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("** point_projection_depth_splat_core: FAILED **");
            $finish;
        end
    end

    task automatic cfg_write(input pdsp_pkg::t_reg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // valid stays up after a beat until the next call decides to idle or send
    task automatic send_beat(input logic cmd, input logic [31:0] wx, input logic [31:0] wy,
                             input logic [31:0] wz, input logic [11:0] ridx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1; i_command <= cmd;
        i_world_x <= wx; i_world_y <= wy; i_world_z <= wz; i_read_index <= ridx;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // small coordinates keep most points on screen
    function automatic logic [31:0] near_coord(input int span);
        return $urandom_range(2 * span) - span;
    endfunction

    task automatic random_phase(input int count);
        int k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(9);
            if (k < 2)
                send_beat(CMD_READ, $urandom, $urandom, $urandom, 12'($urandom));
            else if (k < 3)
                send_beat(CMD_SPLAT, $urandom, $urandom, $urandom, 12'($urandom));
            else
                send_beat(CMD_SPLAT, near_coord(32'h0040_0000), near_coord(32'h0040_0000),
                          $urandom_range(32'h0080_0000, 32'h0001_0000), 12'($urandom));
        end
    endtask

    // camera looking down z, focal length focal/16 pixels, principal point at (32,32)
    task automatic set_camera(input logic [15:0] focal, input logic [15:0] rot_tz);
        cfg_write(pdsp_pkg::REG_ROT_X, 64'h0000_0000_0000_4000);
        cfg_write(pdsp_pkg::REG_ROT_Y, 64'h0000_0000_4000_0000);
        cfg_write(pdsp_pkg::REG_ROT_Z, {rot_tz, 48'h4000_0000_0000});
        cfg_write(pdsp_pkg::REG_INTR_A, {16'd0, 16'h0200, 16'd0, focal});
        cfg_write(pdsp_pkg::REG_INTR_B, {16'd0, 16'h0200, focal, 16'd0});
        cfg_write(pdsp_pkg::REG_INTR_C, {16'd0, 16'h0010, 16'd0, 16'd0});
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: identity setup, extremes, zero divisor, reads of empty entries
        send_beat(CMD_READ, 0, 0, 0, 12'd0);
        send_beat(CMD_READ, 0, 0, 0, 12'hfff);
        send_beat(CMD_SPLAT, 0, 0, 0, 12'd0);
        send_beat(CMD_SPLAT, 32'h0003_0000, 32'h0005_0000, 32'h0001_0000, 12'd0);
        send_beat(CMD_SPLAT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 12'd0);
        send_beat(CMD_SPLAT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 12'd0);
        send_beat(CMD_SPLAT, 32'hffff_8000, 32'h0000_8000, 32'h0001_0000, 12'd0);
        send_beat(CMD_SPLAT, 32'hffff_7fff, 32'h0000_0000, 32'h0001_0000, 12'd0);
        send_beat(CMD_READ, 0, 0, 0, 12'(3 * 64 + 5));
        send_beat(CMD_READ, 0, 0, 0, 12'd0);
        wait_drained();
        set_camera(16'h0100, 16'h0100);
        send_beat(CMD_SPLAT, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 12'd0);
        send_beat(CMD_SPLAT, 32'h0000_0000, 32'h0000_0000, 32'hffff_0000, 12'd0);
        send_beat(CMD_SPLAT, 32'h0000_0000, 32'h0000_0000, 32'hffff_0000, 12'd0);
        send_beat(CMD_SPLAT, 32'h7fff_ffff, 32'h8000_0000, 32'h0100_0000, 12'd0);
        send_beat(CMD_READ, 0, 0, 0, 12'(32 * 64 + 32));
        wait_drained();
        // saturating rotation extremes
        cfg_write(pdsp_pkg::REG_ROT_X, 64'h7fff_7fff_7fff_7fff);
        cfg_write(pdsp_pkg::REG_ROT_Y, 64'h8000_8000_8000_8000);
        cfg_write(pdsp_pkg::REG_ROT_Z, 64'h8000_8000_8000_8000);
        cfg_write(pdsp_pkg::REG_INTR_A, 64'hffff_7fff_8000_7fff);
        cfg_write(pdsp_pkg::REG_INTR_B, 64'hffff_8000_7fff_8000);
        cfg_write(pdsp_pkg::REG_INTR_C, 64'hffff_7fff_7fff_7fff);
        send_beat(CMD_SPLAT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 12'd0);
        send_beat(CMD_SPLAT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 12'd0);
        send_beat(CMD_SPLAT, 32'h1234_5678, 32'h8765_4321, 32'h0000_0001, 12'd0);
        wait_drained();

        set_camera(16'h0200, 16'h0200);
        random_phase(N_RANDOM / 4);
        wait_drained();
        // long hold on the output so the pipeline fills and stalls the input
        fork
            begin
                recv_hold = 1'b1;
                repeat (200) @(negedge i_clk);
                recv_hold = 1'b0;
            end
            random_phase(60);
        join
        wait_drained();
        send_idle_pct = 66;
        recv_idle_pct = 26;
        cfg_write(pdsp_pkg::REG_ROT_X, {$urandom, $urandom} & 64'h00ff_0fff_0fff_7fff);
        cfg_write(pdsp_pkg::REG_ROT_Y, {$urandom, $urandom} & 64'h00ff_0fff_7fff_0fff);
        cfg_write(pdsp_pkg::REG_INTR_A, {16'd0, 16'h0200, 16'h0010, 16'h0400});
        random_phase(N_RANDOM / 4);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_camera(16'h0080, 16'hff00);
        random_phase(N_RANDOM / 4);
        wait_drained();
        cfg_write(pdsp_pkg::REG_ROT_Z, {$urandom, $urandom});
        cfg_write(pdsp_pkg::REG_INTR_C, {$urandom, $urandom});
        random_phase(N_RANDOM / 4);
        for (int i = 0; i < 40; i++) send_beat(CMD_READ, 0, 0, 0, 12'($urandom));
        wait_drained();
        if (errors == 0)
            $display("** point_projection_depth_splat_core: PASSED **");
        else
            $display("** point_projection_depth_splat_core: FAILED **");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/pdsp_pkg.sv
rtl/core/pdsp_div.sv
rtl/core/point_projection_depth_splat_core.sv
tb/pdsp_checker.sv
tb/tb.sv
